[design/mbs_pkg.sv]
// ============================================================================
// mbs_pkg - shared types and constants of the modbus tcp register server
// table sizes, response byte positions, function and exception codes, state
// encoding and the command struct between sequencer and data tables
// ============================================================================
package mbs_pkg;

    // data table sizes
    localparam int COIL_COUNT      = 64;
    localparam int DISCRETE_COUNT  = 64;
    localparam int HOLDING_COUNT   = 16;
    localparam int INPUT_REG_COUNT = 16;

    localparam int BIT_MAX  = (COIL_COUNT > DISCRETE_COUNT) ? COIL_COUNT : DISCRETE_COUNT;
    localparam int WORD_MAX = (HOLDING_COUNT > INPUT_REG_COUNT) ? HOLDING_COUNT
                                                                : INPUT_REG_COUNT;

    // table index widths
    localparam int COIL_AW  = (COIL_COUNT > 1) ? $clog2(COIL_COUNT) : 1;
    localparam int DISC_AW  = (DISCRETE_COUNT > 1) ? $clog2(DISCRETE_COUNT) : 1;
    localparam int HOLD_AW  = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
    localparam int INREG_AW = (INPUT_REG_COUNT > 1) ? $clog2(INPUT_REG_COUNT) : 1;
    localparam int BIT_AW   = (BIT_MAX > 1) ? $clog2(BIT_MAX) : 1;
    localparam int WORD_AW  = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

    // running counters
    localparam int GATHER_BITS = 8;
    localparam int BIT_CW      = $clog2(BIT_MAX + GATHER_BITS + 1);
    localparam int BITCNT_W    = $clog2(BIT_MAX + 1);
    localparam int WORD_CW     = $clog2(WORD_MAX + 1);

    // response framing
    localparam int HDR_LEN   = 7;
    localparam int DATA_POS  = 9;
    localparam int DATA_MAX  = (((BIT_MAX + 7) / 8) > (2 * WORD_MAX)) ? ((BIT_MAX + 7) / 8)
                                                                      : (2 * WORD_MAX);
    localparam int TOTAL_MAX = DATA_MAX + DATA_POS;
    localparam int TOT_W     = $clog2(TOTAL_MAX + 1);

    // byte positions inside the response
    localparam int IDX_TID_HI  = 0;
    localparam int IDX_TID_LO  = 1;
    localparam int IDX_PID_HI  = 2;
    localparam int IDX_PID_LO  = 3;
    localparam int IDX_LEN_HI  = 4;
    localparam int IDX_LEN_LO  = 5;
    localparam int IDX_UNIT    = 6;
    localparam int IDX_FUNC    = 7;
    localparam int IDX_PDU1    = 8;
    localparam int IDX_ADDR_LO = 9;
    localparam int IDX_VAL_HI  = 10;

    // request limits and values
    localparam logic [15:0] QTY_BITS_MAX  = 16'd2000;
    localparam logic [15:0] QTY_WORDS_MAX = 16'd125;
    localparam logic [15:0] COIL_ON       = 16'hFF00;
    localparam logic [15:0] COIL_OFF      = 16'h0000;
    localparam logic [7:0]  EXC_FLAG      = 8'h80;

    // function codes
    localparam logic [7:0] FC_READ_COILS  = 8'd1;
    localparam logic [7:0] FC_READ_DISC   = 8'd2;
    localparam logic [7:0] FC_READ_HOLD   = 8'd3;
    localparam logic [7:0] FC_READ_INREG  = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
    localparam logic [7:0] FC_WRITE_HOLD  = 8'd6;

    typedef enum logic [1:0] {
        MODE_REQ       = 2'd0,
        MODE_SET_DISC  = 2'd1,
        MODE_SET_INREG = 2'd2,
        MODE_NONE      = 2'd3
    } t_mode;

    typedef enum logic [7:0] {
        EXC_NONE          = 8'd0,
        EXC_ILLEGAL_FUNC  = 8'd1,
        EXC_ILLEGAL_ADDR  = 8'd2,
        EXC_ILLEGAL_VALUE = 8'd3
    } t_exc;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_GATHER,
        S_SEND
    } t_state;

    // sequencer to data tables
    typedef struct packed {
        logic               coil_we;
        logic               disc_we;
        logic               bit_wdata;
        logic [BIT_AW-1:0]  bit_waddr;
        logic               hold_we;
        logic               inreg_we;
        logic [15:0]        word_wdata;
        logic [WORD_AW-1:0] word_waddr;
        logic               rd_disc;
        logic [BIT_AW-1:0]  bit_raddr;
        logic               rd_inreg;
        logic [WORD_AW-1:0] word_raddr;
    } t_tab_cmd;

    // one response byte from the sequencer
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_beat;

endpackage

[design/mbs_if.sv]
// ============================================================================
// mbs_if - request and response channels
// valid/ready channels; an item moves when valid and ready are both high
// ============================================================================
interface mbs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] transaction_id;
    logic [15:0] protocol_id;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [15:0] start_index;
    logic [15:0] count_or_value;

    modport source (
        output valid, mode, transaction_id, protocol_id, unit_id,
               function_code, start_index, count_or_value,
        input  ready
    );
    modport sink (
        input  valid, mode, transaction_id, protocol_id, unit_id,
               function_code, start_index, count_or_value,
        output ready
    );
endinterface

interface mbs_resp_if;
    logic       valid;
    logic       ready;
    logic [7:0] response_byte;
    logic       last_byte;

    modport source (
        output valid, response_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, response_byte, last_byte,
        output ready
    );
endinterface

[design/mbs_tables.sv]
// ============================================================================
// mbs_tables - coil, discrete input, holding and input register storage
// bit tables are memories with one write port and a registered read port; word tables are
// small register files read through a mux
// ============================================================================
module mbs_tables (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbs_pkg::t_tab_cmd i_cmd,
    output logic              o_rd_bit,
    output logic [15:0]       o_rd_word
);
    import mbs_pkg::*;

    logic        r_coil_mem  [COIL_COUNT];
    logic        r_disc_mem  [DISCRETE_COUNT];
    logic [15:0] r_hold_words [HOLDING_COUNT];
    logic [15:0] r_inreg_words [INPUT_REG_COUNT];
    logic        r_coil_q;
    logic        r_disc_q;
    logic        r_rd_disc;

    // coil memory, write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.coil_we && (32'(i_cmd.bit_waddr) < 32'(COIL_COUNT))) begin
            r_coil_mem[i_cmd.bit_waddr[COIL_AW-1:0]] <= i_cmd.bit_wdata;
        end
        r_coil_q <= r_coil_mem[i_cmd.bit_raddr[COIL_AW-1:0]];
    end

    // discrete input memory, write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.disc_we && (32'(i_cmd.bit_waddr) < 32'(DISCRETE_COUNT))) begin
            r_disc_mem[i_cmd.bit_waddr[DISC_AW-1:0]] <= i_cmd.bit_wdata;
        end
        r_disc_q  <= r_disc_mem[i_cmd.bit_raddr[DISC_AW-1:0]];
        r_rd_disc <= i_cmd.rd_disc;
    end

    assign o_rd_bit = r_rd_disc ? r_disc_q : r_coil_q;

    // word register files
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HOLDING_COUNT; i++) begin
                r_hold_words[i] <= '0;
            end
            for (int i = 0; i < INPUT_REG_COUNT; i++) begin
                r_inreg_words[i] <= '0;
            end
        end else begin
            if (i_cmd.hold_we) begin
                r_hold_words[i_cmd.word_waddr[HOLD_AW-1:0]] <= i_cmd.word_wdata;
            end
            if (i_cmd.inreg_we) begin
                r_inreg_words[i_cmd.word_waddr[INREG_AW-1:0]] <= i_cmd.word_wdata;
            end
        end
    end

    assign o_rd_word = i_cmd.rd_inreg ? r_inreg_words[i_cmd.word_raddr[INREG_AW-1:0]]
                                      : r_hold_words[i_cmd.word_raddr[HOLD_AW-1:0]];

endmodule

[design/mbs_seq.sv]
// ============================================================================
// mbs_seq - request sequencer
// clears the bit tables after reset, applies updates, checks a request with
// one shared add/compare unit, then walks the response one byte at a time,
// gathering packed bit data one table read per cycle
// ============================================================================
module mbs_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbs_req_if.sink           i_req,
    input  logic              i_rd_bit,
    input  logic [15:0]       i_rd_word,
    output mbs_pkg::t_tab_cmd o_cmd,
    output mbs_pkg::t_beat    o_beat,
    input  logic              i_beat_ready
);
    import mbs_pkg::*;

    t_state r_state, n_state;
    logic [BITCNT_W-1:0] r_clr, n_clr;

    logic [15:0]         r_tid, n_tid;
    logic [15:0]         r_pid, n_pid;
    logic [7:0]          r_unit, n_unit;
    logic [7:0]          r_fc, n_fc;
    logic [15:0]         r_addr, n_addr;
    logic [15:0]         r_cv, n_cv;
    t_exc                r_exc, n_exc;
    logic [7:0]          r_n, n_n;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [TOT_W-1:0]    r_idx, n_idx;
    logic                r_is_bits, n_is_bits;
    logic                r_is_words, n_is_words;
    logic [BIT_CW-1:0]   r_bitaddr, n_bitaddr;
    logic [BITCNT_W-1:0] r_rem, n_rem;
    logic [3:0]          r_gcnt, n_gcnt;
    logic                r_vd, n_vd;
    logic [7:0]          r_byte, n_byte;
    logic [WORD_CW-1:0]  r_waddr, n_waddr;
    logic                r_hi, n_hi;

    logic        accept;
    logic        is_last;
    logic        to_gather;
    logic [TOT_W-1:0] idx_inc;

    // request check results
    logic        chk_read;
    logic        chk_bits;
    logic [16:0] chk_sum;
    logic [16:0] chk_limit;
    t_exc        chk_exc;
    logic [7:0]  chk_n;
    logic [TOT_W-1:0] chk_total;
    logic [15:0] len16;

    assign accept    = i_req.valid && i_req.ready;
    assign is_last   = (r_idx == (r_total - TOT_W'(1)));
    assign idx_inc   = r_idx + TOT_W'(1);
    assign to_gather = r_is_bits && (idx_inc >= TOT_W'(DATA_POS));

    // shared add/compare unit: start + quantity, or start + 1 for a single write, against the table size
    always_comb begin
        chk_read  = (r_fc >= FC_READ_COILS) && (r_fc <= FC_READ_INREG);
        chk_bits  = (r_fc == FC_READ_COILS) || (r_fc == FC_READ_DISC);
        chk_sum   = {1'b0, r_addr} + {1'b0, (r_fc == FC_WRITE_COIL || r_fc == FC_WRITE_HOLD)
                                            ? 16'd1 : r_cv};
        case (r_fc) inside
            FC_READ_COILS, FC_WRITE_COIL: chk_limit = 17'(COIL_COUNT);
            FC_READ_DISC:                 chk_limit = 17'(DISCRETE_COUNT);
            FC_READ_HOLD, FC_WRITE_HOLD:  chk_limit = 17'(HOLDING_COUNT);
            default:                      chk_limit = 17'(INPUT_REG_COUNT);
        endcase

        if (chk_read) begin
            if ((r_cv == 16'd0) || (r_cv > (chk_bits ? QTY_BITS_MAX : QTY_WORDS_MAX))) begin
                chk_exc = EXC_ILLEGAL_VALUE;
            end else if (chk_sum > chk_limit) begin
                chk_exc = EXC_ILLEGAL_ADDR;
            end else begin
                chk_exc = EXC_NONE;
            end
        end else if (r_fc == FC_WRITE_COIL) begin
            if ((r_cv != COIL_ON) && (r_cv != COIL_OFF)) begin
                chk_exc = EXC_ILLEGAL_VALUE;
            end else if (chk_sum > chk_limit) begin
                chk_exc = EXC_ILLEGAL_ADDR;
            end else begin
                chk_exc = EXC_NONE;
            end
        end else if (r_fc == FC_WRITE_HOLD) begin
            chk_exc = (chk_sum > chk_limit) ? EXC_ILLEGAL_ADDR : EXC_NONE;
        end else begin
            chk_exc = EXC_ILLEGAL_FUNC;
        end

        chk_n = chk_bits ? 8'(({1'b0, r_cv} + 17'd7) >> 3) : 8'(r_cv << 1);
        if (chk_exc != EXC_NONE) begin
            chk_total = TOT_W'(HDR_LEN + 2);
        end else if (chk_read) begin
            chk_total = TOT_W'(chk_n) + TOT_W'(HDR_LEN + 2);
        end else begin
            chk_total = TOT_W'(HDR_LEN + 5);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == BITCNT_W'(BIT_MAX - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && (t_mode'(i_req.mode) == MODE_REQ)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_beat_ready) begin
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else if (to_gather) begin
                        n_state = S_GATHER;
                    end
                end
            end
            S_GATHER: begin
                if (r_gcnt == 4'(GATHER_BITS)) begin
                    n_state = S_SEND;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: ready, table commands, response byte
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        o_cmd            = '0;
        o_cmd.rd_disc    = (r_fc == FC_READ_DISC);
        o_cmd.bit_raddr  = r_bitaddr[BIT_AW-1:0];
        o_cmd.rd_inreg   = (r_fc == FC_READ_INREG);
        o_cmd.word_raddr = r_waddr[WORD_AW-1:0];
        o_beat           = '0;
        len16            = 16'(r_total) - 16'(HDR_LEN - 1);

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.coil_we   = 1'b1;
                o_cmd.disc_we   = 1'b1;
                o_cmd.bit_waddr = r_clr[BIT_AW-1:0];
            end
            S_IDLE: begin
                o_cmd.bit_waddr  = i_req.start_index[BIT_AW-1:0];
                o_cmd.bit_wdata  = (i_req.count_or_value != 16'd0);
                o_cmd.word_waddr = i_req.start_index[WORD_AW-1:0];
                o_cmd.word_wdata = i_req.count_or_value;
                o_cmd.disc_we    = accept && (t_mode'(i_req.mode) == MODE_SET_DISC)
                                   && (32'(i_req.start_index) < 32'(DISCRETE_COUNT));
                o_cmd.inreg_we   = accept && (t_mode'(i_req.mode) == MODE_SET_INREG)
                                   && (32'(i_req.start_index) < 32'(INPUT_REG_COUNT));
            end
            S_CHECK: begin
                o_cmd.bit_waddr  = r_addr[BIT_AW-1:0];
                o_cmd.bit_wdata  = (r_cv == COIL_ON);
                o_cmd.word_waddr = r_addr[WORD_AW-1:0];
                o_cmd.word_wdata = r_cv;
                o_cmd.coil_we    = (r_fc == FC_WRITE_COIL) && (chk_exc == EXC_NONE);
                o_cmd.hold_we    = (r_fc == FC_WRITE_HOLD) && (chk_exc == EXC_NONE);
            end
            S_SEND: begin
                o_beat.valid = 1'b1;
                o_beat.last  = is_last;
                unique case (r_idx)
                    TOT_W'(IDX_TID_HI): o_beat.data = r_tid[15:8];
                    TOT_W'(IDX_TID_LO): o_beat.data = r_tid[7:0];
                    TOT_W'(IDX_PID_HI): o_beat.data = r_pid[15:8];
                    TOT_W'(IDX_PID_LO): o_beat.data = r_pid[7:0];
                    TOT_W'(IDX_LEN_HI): o_beat.data = len16[15:8];
                    TOT_W'(IDX_LEN_LO): o_beat.data = len16[7:0];
                    TOT_W'(IDX_UNIT):   o_beat.data = r_unit;
                    TOT_W'(IDX_FUNC): begin
                        o_beat.data = (r_exc != EXC_NONE) ? (r_fc | EXC_FLAG) : r_fc;
                    end
                    TOT_W'(IDX_PDU1): begin
                        if (r_exc != EXC_NONE) begin
                            o_beat.data = r_exc;
                        end else if (r_is_bits || r_is_words) begin
                            o_beat.data = r_n;
                        end else begin
                            o_beat.data = r_addr[15:8];
                        end
                    end
                    default: begin
                        if (r_is_bits) begin
                            o_beat.data = r_byte;
                        end else if (r_is_words) begin
                            o_beat.data = r_hi ? i_rd_word[15:8] : i_rd_word[7:0];
                        end else if (r_idx == TOT_W'(IDX_ADDR_LO)) begin
                            o_beat.data = r_addr[7:0];
                        end else if (r_idx == TOT_W'(IDX_VAL_HI)) begin
                            o_beat.data = r_cv[15:8];
                        end else begin
                            o_beat.data = r_cv[7:0];
                        end
                    end
                endcase
            end
            S_GATHER: begin
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_clr      = r_clr;
        n_tid      = r_tid;
        n_pid      = r_pid;
        n_unit     = r_unit;
        n_fc       = r_fc;
        n_addr     = r_addr;
        n_cv       = r_cv;
        n_exc      = r_exc;
        n_n        = r_n;
        n_total    = r_total;
        n_idx      = r_idx;
        n_is_bits  = r_is_bits;
        n_is_words = r_is_words;
        n_bitaddr  = r_bitaddr;
        n_rem      = r_rem;
        n_gcnt     = r_gcnt;
        n_vd       = r_vd;
        n_byte     = r_byte;
        n_waddr    = r_waddr;
        n_hi       = r_hi;

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + BITCNT_W'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_tid  = i_req.transaction_id;
                    n_pid  = i_req.protocol_id;
                    n_unit = i_req.unit_id;
                    n_fc   = i_req.function_code;
                    n_addr = i_req.start_index;
                    n_cv   = i_req.count_or_value;
                end
            end
            S_CHECK: begin
                n_exc      = chk_exc;
                n_n        = chk_n;
                n_total    = chk_total;
                n_idx      = '0;
                n_is_bits  = chk_read && chk_bits && (chk_exc == EXC_NONE);
                n_is_words = chk_read && !chk_bits && (chk_exc == EXC_NONE);
                n_bitaddr  = r_addr[BIT_CW-1:0];
                n_rem      = r_cv[BITCNT_W-1:0];
                n_waddr    = r_addr[WORD_CW-1:0];
                n_hi       = 1'b1;
            end
            S_SEND: begin
                if (i_beat_ready) begin
                    n_idx = idx_inc;
                    if (r_is_words && (r_idx >= TOT_W'(DATA_POS))) begin
                        n_hi = !r_hi;
                        if (!r_hi) begin
                            n_waddr = r_waddr + WORD_CW'(1);
                        end
                    end
                    n_gcnt = '0;
                    n_byte = '0;
                end
            end
            S_GATHER: begin
                // issue one bit read per cycle, take the bit from the registered read in the next cycle
                if (r_gcnt < 4'(GATHER_BITS)) begin
                    n_bitaddr = r_bitaddr + BIT_CW'(1);
                    n_vd      = (r_rem != '0);
                    if (r_rem != '0) begin
                        n_rem = r_rem - BITCNT_W'(1);
                    end
                end
                if (r_gcnt != 4'd0) begin
                    n_byte = {i_rd_bit & r_vd, r_byte[7:1]};
                end
                n_gcnt = r_gcnt + 4'd1;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_tid      <= n_tid;
        r_pid      <= n_pid;
        r_unit     <= n_unit;
        r_fc       <= n_fc;
        r_addr     <= n_addr;
        r_cv       <= n_cv;
        r_exc      <= n_exc;
        r_n        <= n_n;
        r_total    <= n_total;
        r_idx      <= n_idx;
        r_is_bits  <= n_is_bits;
        r_is_words <= n_is_words;
        r_bitaddr  <= n_bitaddr;
        r_rem      <= n_rem;
        r_gcnt     <= n_gcnt;
        r_vd       <= n_vd;
        r_byte     <= n_byte;
        r_waddr    <= n_waddr;
        r_hi       <= n_hi;
    end

    // a request always goes to the check step
    a_req_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.mode == MODE_REQ)) |=> (r_state == S_CHECK))
        else $error("request not followed by check");

    // the byte pointer never runs past the response length
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> (r_idx < r_total))
        else $error("byte pointer beyond response");

    // bit gathering only for a successful bit read
    a_gather_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GATHER) |-> (r_is_bits && (r_exc == EXC_NONE)))
        else $error("bit gather outside a bit read");

    // the final byte returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_beat.valid && o_beat.last && i_beat_ready) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final byte");

endmodule

[design/modbus_tcp_register_server.sv]
// ============================================================================
// modbus_tcp_register_server - modbus tcp data model with byte-stream replies
// holds coils, discrete inputs, holding and input registers and answers
// read/write-single requests with complete response frames
// ============================================================================
// After reset the block sweeps both bit tables to zero, one entry per cycle,
// and takes no item meanwhile. An update item (set discrete input or input
// register) is written to its table as it is taken. A request is latched,
// then checked, then sends one response byte per cycle while the output side
// takes them: 9 bytes for an exception, 12 for a write echo, 9 + 2 * quantity
// for a word read. A bit read passes through a gather step before each data
// byte, since its eight bits come one per cycle from the single read port of
// the bit memory. A new item is taken only once the last byte of the previous
// response has left the sequencer.
// ============================================================================
module modbus_tcp_register_server (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbs_req_if.sink   i_req,
    mbs_resp_if.source o_resp
);
    import mbs_pkg::*;

    t_tab_cmd    tab_cmd;
    t_beat       beat;
    logic        beat_ready;
    logic        rd_bit;
    logic [15:0] rd_word;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    mbs_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_rd_bit     (rd_bit),
        .i_rd_word    (rd_word),
        .o_cmd        (tab_cmd),
        .o_beat       (beat),
        .i_beat_ready (beat_ready)
    );

    mbs_tables u_tables (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (tab_cmd),
        .o_rd_bit  (rd_bit),
        .o_rd_word (rd_word)
    );

    // output register
    assign beat_ready = !r_out_valid || o_resp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (beat_ready) begin
            r_out_valid <= beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat_ready && beat.valid) begin
            r_out_byte <= beat.data;
            r_out_last <= beat.last;
        end
    end

    assign o_resp.valid         = r_out_valid;
    assign o_resp.response_byte = r_out_byte;
    assign o_resp.last_byte     = r_out_last;

endmodule

[tb/modbus_tcp_register_server_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// modbus_tcp_register_server_test - self-checking bench for the register server
// drives request and update items in random bursts, stalls the response side
// on a changing pattern, and checks every response byte against a local
// model of the four data tables and the response framing
// ============================================================================
module modbus_tcp_register_server_test;
    import mbs_pkg::*;

    localparam int ITEM_TARGET  = 130;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        t_mode       mode;
        logic [15:0] transaction_id;
        logic [15:0] protocol_id;
        logic [7:0]  unit_id;
        logic [7:0]  function_code;
        logic [15:0] start_index;
        logic [15:0] count_or_value;
    } t_modbus_item;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_reply_byte;

    logic i_clk;
    logic i_rst_n;

    mbs_req_if  req_ch ();
    mbs_resp_if resp_ch ();

    modbus_tcp_register_server dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_resp  (resp_ch)
    );

    // local copy of the data tables
    logic        coil_tab  [COIL_COUNT];
    logic        disc_tab  [DISCRETE_COUNT];
    logic [15:0] hold_tab  [HOLDING_COUNT];
    logic [15:0] inreg_tab [INPUT_REG_COUNT];

    t_modbus_item pending_items[$];
    t_reply_byte  reply_bytes_due[$];
    t_modbus_item on_bus;

    int          item_total;
    int          items_taken;
    int          error_count;
    int          quiet_cycles;
    int          burst_left;
    int          gap_left;
    int          stall_style;
    int unsigned stall_clock;
    logic [15:0] next_tid;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // reset
    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic log_error(input string what);
        error_count++;
        if (error_count <= 10)
            $display("%0t ERROR %s", $realtime, what);
    endtask

    // update the tables and queue the response bytes of one item
    task automatic model_request(input t_modbus_item it);
        logic [7:0]  pdu[$];
        logic [7:0]  fc;
        t_exc        exc;
        int unsigned start, qty, limit, nbytes, total;
        logic        is_bit, b;
        logic [15:0] w, adu_len;
        t_reply_byte rb;
        fc    = it.function_code;
        exc   = EXC_NONE;
        start = 32'(it.start_index);
        qty   = 32'(it.count_or_value);
        case (it.mode)
            MODE_SET_DISC: begin
                if (start < DISCRETE_COUNT)
                    disc_tab[start] = (it.count_or_value != 16'd0);
            end
            MODE_SET_INREG: begin
                if (start < INPUT_REG_COUNT)
                    inreg_tab[start] = it.count_or_value;
            end
            MODE_REQ: begin
                if (fc >= FC_READ_COILS && fc <= FC_READ_INREG) begin
                    is_bit = (fc == FC_READ_COILS) || (fc == FC_READ_DISC);
                    if (fc == FC_READ_COILS)      limit = COIL_COUNT;
                    else if (fc == FC_READ_DISC)  limit = DISCRETE_COUNT;
                    else if (fc == FC_READ_HOLD)  limit = HOLDING_COUNT;
                    else                          limit = INPUT_REG_COUNT;
                    // quantity check first, then range without wrap
                    if (qty == 0 || qty > 32'(is_bit ? QTY_BITS_MAX : QTY_WORDS_MAX))
                        exc = EXC_ILLEGAL_VALUE;
                    else if (start + qty > limit)
                        exc = EXC_ILLEGAL_ADDR;
                    else begin
                        nbytes = is_bit ? (qty + 7) / 8 : qty * 2;
                        pdu.push_back(fc);
                        pdu.push_back(nbytes[7:0]);
                        for (int k = 0; k < nbytes; k++)
                            pdu.push_back(8'h00);
                        for (int i = 0; i < qty; i++) begin
                            if (is_bit) begin
                                b = (fc == FC_READ_COILS) ? coil_tab[start + i]
                                                          : disc_tab[start + i];
                                if (b)
                                    pdu[2 + i / 8] = pdu[2 + i / 8] | (8'h01 << (i % 8));
                            end else begin
                                w = (fc == FC_READ_HOLD) ? hold_tab[start + i]
                                                         : inreg_tab[start + i];
                                pdu[2 + 2 * i] = w[15:8];
                                pdu[3 + 2 * i] = w[7:0];
                            end
                        end
                    end
                end else if (fc == FC_WRITE_COIL || fc == FC_WRITE_HOLD) begin
                    // coil value check comes before the range check
                    if (fc == FC_WRITE_COIL && it.count_or_value != COIL_ON
                            && it.count_or_value != COIL_OFF)
                        exc = EXC_ILLEGAL_VALUE;
                    else if (start + 1 > ((fc == FC_WRITE_COIL) ? COIL_COUNT : HOLDING_COUNT))
                        exc = EXC_ILLEGAL_ADDR;
                    else begin
                        if (fc == FC_WRITE_COIL)
                            coil_tab[start] = (it.count_or_value == COIL_ON);
                        else
                            hold_tab[start] = it.count_or_value;
                        pdu.push_back(fc);
                        pdu.push_back(it.start_index[15:8]);
                        pdu.push_back(it.start_index[7:0]);
                        pdu.push_back(it.count_or_value[15:8]);
                        pdu.push_back(it.count_or_value[7:0]);
                    end
                end else begin
                    exc = EXC_ILLEGAL_FUNC;
                end
                if (exc != EXC_NONE) begin
                    pdu.delete();
                    pdu.push_back(fc | EXC_FLAG);
                    pdu.push_back(exc);
                end
                // mbap header ahead of the pdu
                adu_len = 16'(pdu.size() + 1);
                pdu.push_front(it.unit_id);
                pdu.push_front(adu_len[7:0]);
                pdu.push_front(adu_len[15:8]);
                pdu.push_front(it.protocol_id[7:0]);
                pdu.push_front(it.protocol_id[15:8]);
                pdu.push_front(it.transaction_id[7:0]);
                pdu.push_front(it.transaction_id[15:8]);
                total = pdu.size();
                for (int k = 0; k < total; k++) begin
                    rb.data = pdu[k];
                    rb.last = (k == total - 1);
                    reply_bytes_due.push_back(rb);
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_modbus_item make_item(t_mode m, logic [7:0] fc,
                                               logic [15:0] addr, logic [15:0] cv);
        t_modbus_item it;
        it.mode           = m;
        it.transaction_id = next_tid;
        it.protocol_id    = 16'h0000;
        it.unit_id        = 8'h11;
        it.function_code  = fc;
        it.start_index    = addr;
        it.count_or_value = cv;
        next_tid          = next_tid + 16'd1;
        return it;
    endfunction

    // mostly well-formed requests and updates, some broken or noise items
    function automatic t_modbus_item random_item();
        t_modbus_item it;
        int unsigned  pick, start, fc;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            it = make_item(MODE_SET_DISC, 8'($urandom),
                           16'($urandom_range(0, DISCRETE_COUNT - 1)),
                           16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0) it.start_index = 16'($urandom);
        end else if (pick < 24) begin
            it = make_item(MODE_SET_INREG, 8'($urandom),
                           16'($urandom_range(0, INPUT_REG_COUNT - 1)), 16'($urandom));
            if ($urandom_range(0, 7) == 0) it.start_index = 16'($urandom);
        end else if (pick < 27) begin
            it = make_item(MODE_NONE, 8'($urandom), 16'($urandom), 16'($urandom));
        end else if (pick < 82) begin
            fc = $urandom_range(FC_READ_COILS, FC_WRITE_HOLD);
            it = make_item(MODE_REQ, 8'(fc), 16'd0, 16'd0);
            case (8'(fc)) inside
                FC_READ_COILS, FC_READ_DISC: begin
                    start = $urandom_range(0, BIT_MAX - 1);
                    it.start_index    = 16'(start);
                    it.count_or_value = 16'(($urandom_range(0, 5) == 0)
                        ? $urandom_range(1, BIT_MAX - start)
                        : $urandom_range(1, (BIT_MAX - start < 12) ? BIT_MAX - start : 12));
                end
                FC_READ_HOLD, FC_READ_INREG: begin
                    start = $urandom_range(0, WORD_MAX - 1);
                    it.start_index    = 16'(start);
                    it.count_or_value = 16'($urandom_range(1, WORD_MAX - start));
                end
                FC_WRITE_COIL: begin
                    it.start_index    = 16'($urandom_range(0, COIL_COUNT - 1));
                    it.count_or_value = $urandom_range(0, 1) ? COIL_ON : COIL_OFF;
                end
                default: begin
                    it.start_index    = 16'($urandom_range(0, HOLDING_COUNT - 1));
                    it.count_or_value = 16'($urandom);
                end
            endcase
        end else if (pick < 94) begin
            it = make_item(MODE_REQ, 8'($urandom_range(FC_READ_COILS, FC_WRITE_HOLD)),
                           16'($urandom), 16'($urandom));
        end else begin
            it = make_item(MODE_REQ, 8'($urandom), 16'($urandom), 16'($urandom));
        end
        it.transaction_id = 16'($urandom);
        it.unit_id        = 8'($urandom);
        if ($urandom_range(0, 7) == 0) it.protocol_id = 16'($urandom);
        return it;
    endfunction

    // stimulus list and end of run
    initial begin
        t_modbus_item it;
        int           counted;
        error_count = 0;
        items_taken = 0;
        next_tid    = 16'h0100;
        foreach (coil_tab[i])  coil_tab[i]  = 1'b0;
        foreach (disc_tab[i])  disc_tab[i]  = 1'b0;
        foreach (hold_tab[i])  hold_tab[i]  = '0;
        foreach (inreg_tab[i]) inreg_tab[i] = '0;

        // directed: field extremes, every function, each exception path
        it = make_item(MODE_REQ, FC_READ_COILS, 16'd0, 16'(COIL_COUNT));
        it.transaction_id = 16'hFFFF;
        it.protocol_id    = 16'hFFFF;
        it.unit_id        = 8'hFF;
        pending_items.push_back(it);
        it = make_item(MODE_REQ, FC_WRITE_COIL, 16'd0, COIL_ON);
        it.transaction_id = 16'h0000;
        it.unit_id        = 8'h00;
        pending_items.push_back(it);
        pending_items.push_back(make_item(MODE_REQ, FC_WRITE_COIL, 16'(COIL_COUNT - 1), COIL_ON));
        pending_items.push_back(make_item(MODE_REQ, FC_WRITE_COIL, 16'd9, COIL_ON));
        pending_items.push_back(make_item(MODE_REQ, FC_WRITE_COIL, 16'd9, COIL_OFF));
        pending_items.push_back(make_item(MODE_REQ, FC_WRITE_COIL, 16'hFFFF, 16'h1234));
        pending_items.push_back(make_item(MODE_REQ, FC_WRITE_COIL, 16'(COIL_COUNT), COIL_ON));
        pending_items.push_back(make_item(MODE_REQ, FC_WRITE_HOLD, 16'd0, 16'hFFFF));
        pending_items.push_back(make_item(MODE_REQ, FC_WRITE_HOLD, 16'(HOLDING_COUNT - 1),
                                          16'hA55A));
        pending_items.push_back(make_item(MODE_REQ, FC_WRITE_HOLD, 16'(HOLDING_COUNT),
                                          16'h0001));
        pending_items.push_back(make_item(MODE_SET_DISC, 8'h00, 16'd0, 16'h8000));
        pending_items.push_back(make_item(MODE_SET_DISC, 8'hFF, 16'(DISCRETE_COUNT - 1), 16'd1));
        pending_items.push_back(make_item(MODE_SET_DISC, 8'h00, 16'(DISCRETE_COUNT), 16'd1));
        pending_items.push_back(make_item(MODE_SET_INREG, 8'h00, 16'(INPUT_REG_COUNT - 1),
                                          16'hFFFF));
        pending_items.push_back(make_item(MODE_SET_INREG, 8'h00, 16'hFFFF, 16'h1234));
        pending_items.push_back(make_item(MODE_REQ, FC_READ_COILS, 16'd0, 16'd9));
        pending_items.push_back(make_item(MODE_REQ, FC_READ_DISC, 16'd0, 16'(DISCRETE_COUNT)));
        pending_items.push_back(make_item(MODE_REQ, FC_READ_HOLD, 16'd0, 16'(HOLDING_COUNT)));
        pending_items.push_back(make_item(MODE_REQ, FC_READ_INREG, 16'd0,
                                          16'(INPUT_REG_COUNT)));
        pending_items.push_back(make_item(MODE_REQ, FC_READ_HOLD, 16'd0, 16'd0));
        pending_items.push_back(make_item(MODE_REQ, FC_READ_INREG, 16'd0, 16'd126));
        pending_items.push_back(make_item(MODE_REQ, FC_READ_HOLD, 16'd0, 16'd125));
        pending_items.push_back(make_item(MODE_REQ, FC_READ_DISC, 16'd0, 16'd2001));
        pending_items.push_back(make_item(MODE_REQ, FC_READ_COILS, 16'd0, 16'd2000));
        pending_items.push_back(make_item(MODE_REQ, FC_READ_HOLD, 16'hFFFF, 16'd1));
        pending_items.push_back(make_item(MODE_REQ, 8'd0, 16'd0, 16'd1));
        pending_items.push_back(make_item(MODE_REQ, 8'd16, 16'd0, 16'd1));
        pending_items.push_back(make_item(MODE_REQ, 8'hFF, 16'd0, 16'd1));
        pending_items.push_back(make_item(MODE_NONE, FC_READ_COILS, 16'd0, 16'd1));

        // random part; ignored items do not count
        counted = 0;
        while (counted < ITEM_TARGET) begin
            it = random_item();
            if (it.mode != MODE_NONE) counted++;
            pending_items.push_back(it);
        end
        item_total = pending_items.size();

        wait (i_rst_n === 1'b1);
        while (items_taken < item_total) @(posedge i_clk);
        while (reply_bytes_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (reply_bytes_due.size() != 0)
            log_error($sformatf("%0d response bytes never arrived", reply_bytes_due.size()));
        if (error_count == 0)
            $display("** modbus_tcp_register_server: PASSED **");
        else
            $display("** modbus_tcp_register_server: FAILED **");
        $finish;
    end

    // request driver: bursts of items with random gaps
    always @(posedge i_clk) begin
        logic busy;
        if (!i_rst_n) begin
            req_ch.valid          <= 1'b0;
            req_ch.mode           <= MODE_NONE;
            req_ch.transaction_id <= '0;
            req_ch.protocol_id    <= '0;
            req_ch.unit_id        <= '0;
            req_ch.function_code  <= '0;
            req_ch.start_index    <= '0;
            req_ch.count_or_value <= '0;
            burst_left = $urandom_range(1, 8);
            gap_left   = 0;
        end else begin
            busy = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                model_request(on_bus);
                items_taken++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    on_bus = pending_items.pop_front();
                    req_ch.valid          <= 1'b1;
                    req_ch.mode           <= on_bus.mode;
                    req_ch.transaction_id <= on_bus.transaction_id;
                    req_ch.protocol_id    <= on_bus.protocol_id;
                    req_ch.unit_id        <= on_bus.unit_id;
                    req_ch.function_code  <= on_bus.function_code;
                    req_ch.start_index    <= on_bus.start_index;
                    req_ch.count_or_value <= on_bus.count_or_value;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and receiver stall pattern
    always @(posedge i_clk) begin
        t_reply_byte due;
        if (!i_rst_n) begin
            resp_ch.ready <= 1'b0;
            stall_clock = 0;
            stall_style = 0;
        end else begin
            if (resp_ch.valid && resp_ch.ready) begin
                if (reply_bytes_due.size() == 0) begin
                    log_error($sformatf("unexpected response byte %02h last %b",
                                        resp_ch.response_byte, resp_ch.last_byte));
                end else begin
                    due = reply_bytes_due.pop_front();
                    if (resp_ch.response_byte !== due.data)
                        log_error($sformatf("response_byte expected %02h got %02h",
                                            due.data, resp_ch.response_byte));
                    if (resp_ch.last_byte !== due.last)
                        log_error($sformatf("last_byte expected %b got %b (byte %02h)",
                                            due.last, resp_ch.last_byte, due.data));
                end
            end
            // the stall style is picked anew at random, one of four
            stall_clock++;
            if (stall_clock % 53 == 0)
                stall_style = $urandom_range(0, 3);
            case (stall_style)
                0:       resp_ch.ready <= 1'b1;
                1:       resp_ch.ready <= 1'($urandom_range(0, 1));
                2:       resp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: resp_ch.ready <= (stall_clock % 7 != 0);
            endcase
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("** modbus_tcp_register_server: FAILED **");
        $finish;
    end

endmodule
